/* design/sorted_list_engine_unit_macros.svh */
// ----------------------------------------------------------------------------
// sorted list engine assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_UNIT_MACROS_SVH
`define SORTED_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define SLE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted list engine assertion failed");

// next-cycle implication
`define SLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted list engine assertion failed");

`endif

/* design/slu_pkg.sv */
// ----------------------------------------------------------------------------
// slu_pkg
// types and constants shared by the sorted list engine cells, chain and top
// ----------------------------------------------------------------------------
package slu_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int OP_W   = 2;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT       = 2'd0,
        OP_REMOVE_VALUE = 2'd1,
        OP_GET          = 2'd2,
        OP_REMOVE_POS   = 2'd3
    } op_t;

    // broadcast to every cell during the execute cycle
    typedef struct packed {
        logic              ins_en;
        logic              rval_en;
        logic              rpos_en;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  pos;
    } cmd_t;

    // chain results back to the control
    typedef struct packed {
        logic              rval_hit;
        logic [DATA_W-1:0] rd_value;
    } chain_status_t;

endpackage

/* design/slu_cell.sv */
// ----------------------------------------------------------------------------
// slu_cell
// one list slot: holds an entry, compares it, shifts from a neighbor
// ----------------------------------------------------------------------------
module slu_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                        aclk,
    input  slu_pkg::cmd_t               cmd,
    input  logic [CNT_W-1:0]            count,
    input  logic                        left_less,
    input  logic [slu_pkg::DATA_W-1:0]  left_value,
    input  logic [slu_pkg::DATA_W-1:0]  right_value,
    output logic                        less,
    output logic                        hit,
    output logic [slu_pkg::DATA_W-1:0]  value
);

    localparam int CMP_W = (CNT_W > slu_pkg::POS_W) ? CNT_W : slu_pkg::POS_W;

    logic [slu_pkg::DATA_W-1:0] value_reg;
    logic [slu_pkg::DATA_W-1:0] value_next;
    logic                       valid;
    logic                       at_pos;

    assign valid  = CMP_W'(INDEX) < CMP_W'(count);
    assign at_pos = CMP_W'(INDEX) >= CMP_W'(cmd.pos);
    assign less   = valid && ($signed(value_reg) < $signed(cmd.value));
    // first slot that is not smaller, holding an equal entry
    assign hit    = valid && left_less && !less && (value_reg == cmd.value);
    assign value  = value_reg;

    always_comb begin
        value_next = value_reg;
        if (cmd.ins_en && !less) begin
            value_next = left_less ? cmd.value : left_value;
        end else if (cmd.rval_en && !less) begin
            value_next = right_value;
        end else if (cmd.rpos_en && at_pos) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

/* design/slu_chain.sv */
// ----------------------------------------------------------------------------
// slu_chain
// row of list cells with neighbor links, match reduction and read select
// ----------------------------------------------------------------------------
module slu_chain #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input  logic                   aclk,
    input  slu_pkg::cmd_t          cmd,
    input  logic [CNT_W-1:0]       count,
    output slu_pkg::chain_status_t status
);

    // positions carried by the request only reach the first 31 slots
    localparam int RD_N = (CAPACITY < 31) ? CAPACITY : 31;

    logic [CAPACITY-1:0]             less;
    logic [CAPACITY-1:0]             hit;
    logic [slu_pkg::DATA_W-1:0]      values [CAPACITY];
    logic [slu_pkg::POS_W-1:0]       rd_idx;
    logic [slu_pkg::DATA_W-1:0]      rd_value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                       left_less;
        logic [slu_pkg::DATA_W-1:0] left_value;
        logic [slu_pkg::DATA_W-1:0] right_value;

        if (i == 0) begin : g_head
            assign left_less  = 1'b1;
            assign left_value = cmd.value;
        end else begin : g_body
            assign left_less  = less[i-1];
            assign left_value = values[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_value = values[i];
        end else begin : g_inner
            assign right_value = values[i+1];
        end

        slu_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .count       (count),
            .left_less   (left_less),
            .left_value  (left_value),
            .right_value (right_value),
            .less        (less[i]),
            .hit         (hit[i]),
            .value       (values[i])
        );
    end

    assign rd_idx = cmd.pos - slu_pkg::POS_W'(1);

    always_comb begin
        rd_value = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (rd_idx == slu_pkg::POS_W'(i)) begin
                rd_value = rd_value | values[i];
            end
        end
    end

    assign status.rval_hit = |hit;
    assign status.rd_value = rd_value;

endmodule

/* design/sorted_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine_unit
// ascending list of signed 32-bit entries kept in a row of shifting cells
// ----------------------------------------------------------------------------
// A request arrives on s_valid/s_ready with s_operation, s_item_value and
// s_position; insert, remove by value, get (1-based) and remove at position
// (0-based). Each request gives one result on m_valid/m_ready carrying
// m_success, m_read_value (nonzero only for a successful get) and
// m_entry_count, the count after the request.
// The request is held in the request register and then executes; its result
// is registered in the result register. The cells compare against the
// request value in parallel and shift once, in the execute cycle; a new
// request is not taken until the current one has executed.
// Only one request is held at a time; s_ready drops while it executes.
// If the receiver stalls, the result register keeps the result and the next
// request is still taken; it waits in the request register and executes in
// the cycle the result slot frees.
// Reset (aresetn low, synchronous) empties the list and clears both
// handshakes; no clearing pass is needed, entries past the count are unused.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [slu_pkg::OP_W-1:0]           s_operation,
    input  logic signed [slu_pkg::DATA_W-1:0]  s_item_value,
    input  logic [slu_pkg::POS_W-1:0]          s_position,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_success,
    output logic signed [slu_pkg::DATA_W-1:0]  m_read_value,
    output logic [slu_pkg::OUT_CNT_W-1:0]      m_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > slu_pkg::POS_W) ? CNT_W : slu_pkg::POS_W;

    logic                         busy_reg;
    logic                         busy_next;
    slu_pkg::op_t                 op_reg;
    logic [slu_pkg::DATA_W-1:0]   value_reg;
    logic [slu_pkg::POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_success_reg;
    logic                         out_success_next;
    logic [slu_pkg::DATA_W-1:0]   out_read_reg;
    logic [slu_pkg::DATA_W-1:0]   out_read_next;
    logic [CNT_W-1:0]             out_count_reg;

    logic                         accept;
    logic                         exec;
    logic                         ins_ok;
    logic                         get_ok;
    logic                         rpos_ok;
    logic                         rval_ok;
    slu_pkg::cmd_t                cmd;
    slu_pkg::chain_status_t       status;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign exec    = busy_reg && (!out_valid_reg || m_ready);

    assign ins_ok  = count_reg < CNT_W'(CAPACITY);
    assign get_ok  = (pos_reg != '0) && (CMP_W'(pos_reg) <= CMP_W'(count_reg));
    assign rpos_ok = CMP_W'(pos_reg) < CMP_W'(count_reg);
    assign rval_ok = status.rval_hit;

    assign cmd.ins_en  = exec && (op_reg == slu_pkg::OP_INSERT) && ins_ok;
    assign cmd.rval_en = exec && (op_reg == slu_pkg::OP_REMOVE_VALUE) && rval_ok;
    assign cmd.rpos_en = exec && (op_reg == slu_pkg::OP_REMOVE_POS) && rpos_ok;
    assign cmd.value   = value_reg;
    assign cmd.pos     = pos_reg;

    slu_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain (
        .aclk   (aclk),
        .cmd    (cmd),
        .count  (count_reg),
        .status (status)
    );

    always_comb begin
        busy_next        = busy_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        out_success_next = 1'b0;
        out_read_next    = '0;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        case (op_reg)
            slu_pkg::OP_INSERT:       out_success_next = ins_ok;
            slu_pkg::OP_REMOVE_VALUE: out_success_next = rval_ok;
            slu_pkg::OP_GET:          out_success_next = get_ok;
            slu_pkg::OP_REMOVE_POS:   out_success_next = rpos_ok;
            default:                  out_success_next = 1'b0;
        endcase

        if ((op_reg == slu_pkg::OP_GET) && get_ok) begin
            out_read_next = status.rd_value;
        end

        if (cmd.ins_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.rval_en || cmd.rpos_en) begin
            count_next = count_reg - CNT_W'(1);
        end

        if (exec) begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= slu_pkg::op_t'(s_operation);
            value_reg <= s_item_value;
            pos_reg   <= s_position;
        end
        if (exec) begin
            out_success_reg <= out_success_next;
            out_read_reg    <= out_read_next;
            out_count_reg   <= count_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_success     = out_success_reg;
    assign m_read_value  = out_read_reg;
    assign m_entry_count = slu_pkg::OUT_CNT_W'(out_count_reg);

endmodule

/* design/slu_checker.sv */
// ----------------------------------------------------------------------------
// slu_checker
// port-level checks for the sorted list engine, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_list_engine_unit_macros.svh"

module slu_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_success,
    input logic signed [slu_pkg::DATA_W-1:0]  m_read_value,
    input logic [slu_pkg::OUT_CNT_W-1:0]      m_entry_count
);

    // stalled result holds
    `SLE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_value) && $stable(m_entry_count) && $stable(m_success))

    // one request in flight: ready drops right after a request
    `SLE_ASSERT_NEXT(a_one_req, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a failed request never returns data
    `SLE_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_valid && !m_success, m_read_value == '0)

endmodule

bind sorted_list_engine_unit slu_checker u_slu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_success     (m_success),
    .m_read_value  (m_read_value),
    .m_entry_count (m_entry_count)
);
